>>> design/lfsr_dither_requantizer_top_assert.svh
// Assertion macros used by the requantizer queue.
`ifndef LFSR_DITHER_REQUANTIZER_TOP_ASSERT_SVH
`define LFSR_DITHER_REQUANTIZER_TOP_ASSERT_SVH

// same-cycle implication
`define LDRQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ldrq assertion failed");

// next-cycle implication
`define LDRQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ldrq assertion failed");

`endif

>>> design/ldrq_pkg.sv
// Types, constants and functions for the LFSR dither requantizer.
package ldrq_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [1:0] REG_TARGET_BITS = 2'd0;
    localparam logic [1:0] REG_ALPHA_Q16   = 2'd1;
    localparam logic [1:0] REG_MULAW_MODE  = 2'd2;
    localparam logic [1:0] REG_LFSR_SEED   = 2'd3;

    localparam logic [4:0]  TARGET_BITS_MIN   = 5'd1;
    localparam logic [4:0]  TARGET_BITS_MAX   = 5'd16;
    localparam logic [16:0] ALPHA_MAX         = 17'd65536;
    localparam logic [31:0] LFSR_SEED_RESET   = 32'd1;

    localparam logic [13:0] MU_CLIP     = 14'd8159;
    localparam logic [13:0] MU_BIAS_MAG = 14'd33;
    localparam logic [7:0]  MU_FLIP_POS = 8'hFF;
    localparam logic [7:0]  MU_FLIP_NEG = 8'h7F;

    localparam logic signed [17:0] SUM_MAX = 18'sd32767;
    localparam logic signed [17:0] SUM_MIN = -18'sd32768;

    typedef logic [QCNT_W-1:0] qcnt_t;
    typedef logic [QPTR_W-1:0] qptr_t;

    typedef struct packed {
        logic signed [15:0] pcm_in;
        logic               last_in;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] pcm_out;
        logic               last_out;
    } result_t;

    // request handed from front to back
    typedef struct packed {
        logic signed [15:0] base;
        logic [31:0]        noise;
        logic               dith_en;
        logic               last;
    } work_t;

    typedef struct packed {
        logic [16:0] alpha;
        logic        mulaw;
        logic        seed_load;
        logic [31:0] seed;
    } front_cfg_t;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] step_mask;
        logic [15:0] half_step;
    } back_cfg_t;

    function automatic logic [31:0] lfsr_next(input logic [31:0] s);
        logic fb;
        fb = s[31] ^ s[21] ^ s[1] ^ s[0];
        return {fb, s[31:1]};
    endfunction

    function automatic logic [7:0] mulaw_code(input logic signed [15:0] x);
        logic signed [15:0] q;
        logic [15:0]        nq;
        logic [13:0]        mag;
        logic [7:0]         flip;
        logic [3:0]         seg;
        logic [13:0]        sh;
        logic [7:0]         code;
        q = x >>> 2;
        nq = -q;
        if (x[15])
        begin
            mag  = nq[13:0];
            flip = MU_FLIP_NEG;
        end
        else
        begin
            mag  = q[13:0];
            flip = MU_FLIP_POS;
        end
        if (mag > MU_CLIP)
        begin
            mag = MU_CLIP;
        end
        mag = mag + MU_BIAS_MAG;
        priority if (mag <= 14'h003F) seg = 4'd0;
        else if (mag <= 14'h007F) seg = 4'd1;
        else if (mag <= 14'h00FF) seg = 4'd2;
        else if (mag <= 14'h01FF) seg = 4'd3;
        else if (mag <= 14'h03FF) seg = 4'd4;
        else if (mag <= 14'h07FF) seg = 4'd5;
        else if (mag <= 14'h0FFF) seg = 4'd6;
        else if (mag <= 14'h1FFF) seg = 4'd7;
        else seg = 4'd8;
        sh = mag >> (seg + 4'd1);
        if (seg[3])
        begin
            code = MU_FLIP_NEG ^ flip;
        end
        else
        begin
            code = {1'b0, seg[2:0], sh[3:0]} ^ flip;
        end
        return code;
    endfunction

endpackage

>>> design/lfsr_dither_requantizer_top.sv
// Top level of the LFSR dither requantizer: registers, front, queue and back.
// One sample in and one sample out per clock when neither side stalls. The
// front steps the 32-bit noise LFSR once or twice per request in the cycle
// it accepts it, which is what holds the rate at one request per cycle while
// the queue has room; a four-entry queue then feeds the back end, whose
// multiply stage register and output register follow the queue.
// Target bits and alpha are saturated when written; writing the seed reloads
// the noise generator. Change registers only while the block is idle.
module lfsr_dither_requantizer_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  ldrq_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_stall,
    output ldrq_pkg::result_t result,
    input  logic              wr_en,
    input  logic [1:0]        wr_index,
    input  logic [31:0]       wr_data
);

    logic [4:0]  tbits_reg;
    logic [16:0] alpha_reg;
    logic        mulaw_reg;

    logic [4:0]  tbits_wr;
    logic [16:0] alpha_wr;
    logic [15:0] step;

    ldrq_pkg::front_cfg_t front_cfg;
    ldrq_pkg::back_cfg_t  back_cfg;

    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_valid;
    ldrq_pkg::work_t wr_entry;
    ldrq_pkg::work_t rd_entry;

    always_comb
    begin
        priority if (wr_data[4:0] < ldrq_pkg::TARGET_BITS_MIN) tbits_wr = ldrq_pkg::TARGET_BITS_MIN;
        else if (wr_data[4:0] > ldrq_pkg::TARGET_BITS_MAX) tbits_wr = ldrq_pkg::TARGET_BITS_MAX;
        else tbits_wr = wr_data[4:0];
        alpha_wr = (wr_data[16:0] > ldrq_pkg::ALPHA_MAX) ? ldrq_pkg::ALPHA_MAX : wr_data[16:0];

        step = 16'h0001 << (ldrq_pkg::TARGET_BITS_MAX - tbits_reg);

        front_cfg.alpha     = alpha_reg;
        front_cfg.mulaw     = mulaw_reg;
        front_cfg.seed_load = wr_en && (wr_index == ldrq_pkg::REG_LFSR_SEED);
        front_cfg.seed      = wr_data;

        back_cfg.width     = 16'(alpha_reg >> tbits_reg);
        back_cfg.step_mask = step - 16'h0001;
        back_cfg.half_step = step >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbits_reg <= ldrq_pkg::TARGET_BITS_MAX;
            alpha_reg <= ldrq_pkg::ALPHA_MAX;
            mulaw_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ldrq_pkg::REG_TARGET_BITS: tbits_reg <= tbits_wr;
                ldrq_pkg::REG_ALPHA_Q16:   alpha_reg <= alpha_wr;
                ldrq_pkg::REG_MULAW_MODE:  mulaw_reg <= wr_data[0];
                default:                   ;
            endcase
        end
    end

    assign sample_stall = q_full;

    ldrq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (front_cfg),
        .sample_valid (sample_valid),
        .sample       (sample),
        .q_full       (q_full),
        .push         (push),
        .entry        (wr_entry)
    );

    ldrq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_entry  (wr_entry),
        .pop       (pop),
        .rd_entry  (rd_entry),
        .full      (q_full),
        .not_empty (q_valid)
    );

    ldrq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (back_cfg),
        .q_valid      (q_valid),
        .q_entry      (rd_entry),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule

>>> design/ldrq_front.sv
// Front end: steps the LFSR, decides dither, forms the mu-law or linear base.
module ldrq_front (
    input  logic                clk,
    input  logic                rst_n,
    input  ldrq_pkg::front_cfg_t cfg,
    input  logic                sample_valid,
    input  ldrq_pkg::sample_t   sample,
    input  logic                q_full,
    output logic                push,
    output ldrq_pkg::work_t     entry
);

    logic [31:0] lfsr_reg;
    logic [31:0] lfsr_next;
    logic [31:0] step1;
    logic [31:0] step2;
    logic        take;
    logic [7:0]  code;

    always_comb
    begin
        step1 = ldrq_pkg::lfsr_next(lfsr_reg);
        step2 = ldrq_pkg::lfsr_next(step1);
        take  = {1'b0, step1} <= {cfg.alpha, 16'h0000};
        code  = ldrq_pkg::mulaw_code(sample.pcm_in);
        push  = sample_valid && !q_full;

        entry.base    = cfg.mulaw ? $signed({8'h00, code}) : sample.pcm_in;
        entry.noise   = step2;
        entry.dith_en = take;
        entry.last    = sample.last_in;

        lfsr_next = lfsr_reg;
        if (cfg.seed_load)
        begin
            lfsr_next = cfg.seed;
        end
        else if (push)
        begin
            lfsr_next = take ? step2 : step1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= ldrq_pkg::LFSR_SEED_RESET;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

>>> design/ldrq_queue.sv
// Four-entry request queue between front and back.
`include "lfsr_dither_requantizer_top_assert.svh"

module ldrq_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ldrq_pkg::work_t wr_entry,
    input  logic            pop,
    output ldrq_pkg::work_t rd_entry,
    output logic            full,
    output logic            not_empty
);

    ldrq_pkg::work_t mem [ldrq_pkg::QDEPTH];
    ldrq_pkg::qptr_t wr_ptr_reg;
    ldrq_pkg::qptr_t rd_ptr_reg;
    ldrq_pkg::qcnt_t count_reg;
    ldrq_pkg::qcnt_t count_next;

    assign full      = count_reg == ldrq_pkg::qcnt_t'(ldrq_pkg::QDEPTH);
    assign not_empty = count_reg != ldrq_pkg::qcnt_t'(0);
    assign rd_entry  = mem[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + ldrq_pkg::qcnt_t'(1);
            2'b01:   count_next = count_reg - ldrq_pkg::qcnt_t'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + ldrq_pkg::qptr_t'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + ldrq_pkg::qptr_t'(1);
            end
            count_reg <= count_next;
        end
    end

    `LDRQ_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= ldrq_pkg::qcnt_t'(ldrq_pkg::QDEPTH))
    `LDRQ_ASSERT_IMPL(a_no_pop_empty, pop, not_empty)
    `LDRQ_ASSERT_IMPL(a_no_push_full, push, !full)
    `LDRQ_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + ldrq_pkg::qcnt_t'(1))

endmodule

>>> design/ldrq_back.sv
// Back end: dither multiply, add, clamp, floor to step plus half a step and output register.
module ldrq_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ldrq_pkg::back_cfg_t cfg,
    input  logic                q_valid,
    input  ldrq_pkg::work_t     q_entry,
    output logic                pop,
    output logic                result_valid,
    output ldrq_pkg::result_t   result,
    input  logic                result_stall
);

    logic                advance;
    logic [47:0]         product;

    logic                s1_valid_reg;
    logic [15:0]         s1_u_reg;
    logic                s1_en_reg;
    logic signed [15:0]  s1_base_reg;
    logic                s1_last_reg;

    logic signed [17:0]  dither;
    logic signed [17:0]  sum;
    logic [15:0]         clamped;
    logic [15:0]         quant;

    logic                res_valid_reg;
    ldrq_pkg::result_t   res_reg;

    assign advance      = !res_valid_reg || !result_stall;
    assign pop          = advance && q_valid;
    assign product      = 48'(q_entry.noise) * 48'(cfg.width);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        if (s1_en_reg)
        begin
            dither = $signed({2'b00, s1_u_reg}) - $signed({3'b000, cfg.width[15:1]});
        end
        else
        begin
            dither = '0;
        end
        sum = 18'(s1_base_reg) + dither;
        priority if (sum > ldrq_pkg::SUM_MAX) clamped = ldrq_pkg::SUM_MAX[15:0];
        else if (sum < ldrq_pkg::SUM_MIN) clamped = ldrq_pkg::SUM_MIN[15:0];
        else clamped = sum[15:0];
        quant = (clamped & ~cfg.step_mask) + cfg.half_step;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_u_reg    <= product[47:32];
            s1_en_reg   <= q_entry.dith_en;
            s1_base_reg <= q_entry.base;
            s1_last_reg <= q_entry.last;
        end
        if (advance && s1_valid_reg)
        begin
            res_reg.pcm_out  <= $signed(quant);
            res_reg.last_out <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_valid;
            res_valid_reg <= s1_valid_reg;
        end
    end

endmodule
